>>> src/rgbn_pkg.sv
// Shared constants, types and state encoding for the masked maximum RGB normaliser.
package rgbn_pkg;

    localparam int PIXEL_BITS    = 16;
    localparam int FRACTION_BITS = 16;
    localparam int OUT_BITS      = 20;
    localparam int MASK_BITS     = 16;

    localparam int DIVIDEND_BITS = PIXEL_BITS + FRACTION_BITS;
    localparam int HI_BITS       = DIVIDEND_BITS - OUT_BITS;
    localparam int STEP_BITS     = $clog2(OUT_BITS);

    // Threshold of 0.9 as a 0.16 fraction.
    localparam logic [MASK_BITS-1:0] THRESHOLD_RESET = MASK_BITS'(58982);
    localparam logic [STEP_BITS-1:0] LAST_STEP       = STEP_BITS'(OUT_BITS - 1);

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_SCALE   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } lane_ctrl_t;

endpackage

>>> src/rgbn_if.sv
// Handshake channels for pixels in and normalised pixels out.
interface rgbn_in_if;
    import rgbn_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic                  first_of_frame;
    logic [PIXEL_BITS-1:0] red_in;
    logic [PIXEL_BITS-1:0] green_in;
    logic [PIXEL_BITS-1:0] blue_in;
    logic [MASK_BITS-1:0]  mask_level;

    modport source (
        output valid, mode, first_of_frame, red_in, green_in, blue_in, mask_level,
        input  ready
    );
    modport sink (
        input  valid, mode, first_of_frame, red_in, green_in, blue_in, mask_level,
        output ready
    );
endinterface

interface rgbn_out_if;
    import rgbn_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OUT_BITS-1:0]   red_out;
    logic [OUT_BITS-1:0]   green_out;
    logic [OUT_BITS-1:0]   blue_out;
    logic                  scaled;
    logic [PIXEL_BITS-1:0] frame_maximum;

    modport source (
        output valid, red_out, green_out, blue_out, scaled, frame_maximum,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, scaled, frame_maximum,
        output ready
    );
endinterface

>>> src/rgbn_div_lane.sv
// One channel lane: restoring divider, one quotient bit per cycle, saturation, zero-divisor pass-through.
module rgbn_div_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rgbn_pkg::lane_ctrl_t           ctrl,
    input  logic [rgbn_pkg::PIXEL_BITS-1:0] value,
    input  logic [rgbn_pkg::PIXEL_BITS-1:0] divisor,
    output logic [rgbn_pkg::OUT_BITS-1:0]   result
);
    import rgbn_pkg::*;

    logic [PIXEL_BITS-1:0]    rem_reg;
    logic [OUT_BITS-1:0]      shift_reg;
    logic [PIXEL_BITS-1:0]    raw_reg;
    logic                     sat_reg;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [PIXEL_BITS-1:0]    hi_part;
    logic [PIXEL_BITS:0]      trial;
    logic                     qbit;

    assign dividend = {value, {FRACTION_BITS{1'b0}}};
    assign hi_part  = PIXEL_BITS'(dividend[DIVIDEND_BITS-1 -: HI_BITS]);
    assign trial    = {rem_reg, shift_reg[OUT_BITS-1]};
    assign qbit     = (trial >= {1'b0, divisor});

    // The quotient fits the output only if the bits above it are below the divisor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            sat_reg <= (hi_part >= divisor);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg   <= hi_part;
            shift_reg <= dividend[OUT_BITS-1:0];
            raw_reg   <= value;
        end
        else if (ctrl.step)
        begin
            rem_reg   <= qbit ? PIXEL_BITS'(trial - {1'b0, divisor}) : trial[PIXEL_BITS-1:0];
            shift_reg <= {shift_reg[OUT_BITS-2:0], qbit};
        end
    end

    always_comb
    begin
        if (divisor == '0)
        begin
            result = OUT_BITS'(raw_reg);
        end
        else if (sat_reg)
        begin
            result = '1;
        end
        else
        begin
            result = shift_reg;
        end
    end

endmodule

>>> src/rgbn_merge.sv
// Merging stage: gathers the three lane results into the registered output channel.
module rgbn_merge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [rgbn_pkg::OUT_BITS-1:0]   red_res,
    input  logic [rgbn_pkg::OUT_BITS-1:0]   green_res,
    input  logic [rgbn_pkg::OUT_BITS-1:0]   blue_res,
    input  logic [rgbn_pkg::PIXEL_BITS-1:0] maximum,
    output logic                            can_load,
    rgbn_out_if.source                      pixel_out
);
    import rgbn_pkg::*;

    logic                  valid_reg;
    logic [OUT_BITS-1:0]   red_reg;
    logic [OUT_BITS-1:0]   green_reg;
    logic [OUT_BITS-1:0]   blue_reg;
    logic                  scaled_reg;
    logic [PIXEL_BITS-1:0] max_reg;

    assign can_load = !valid_reg || pixel_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pixel_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg    <= red_res;
            green_reg  <= green_res;
            blue_reg   <= blue_res;
            scaled_reg <= (maximum != '0);
            max_reg    <= maximum;
        end
    end

    assign pixel_out.valid         = valid_reg;
    assign pixel_out.red_out       = red_reg;
    assign pixel_out.green_out     = green_reg;
    assign pixel_out.blue_out      = blue_reg;
    assign pixel_out.scaled        = scaled_reg;
    assign pixel_out.frame_maximum = max_reg;

endmodule

>>> src/masked_max_rgb_normalizer_top.sv
// Top level: maximum tracking, sequencing of the three divider lanes and the output stage.
// A measure pixel is absorbed in the cycle of its transfer and yields no result.
// A scale pixel is divided by the maximum in three parallel lanes, one quotient bit per cycle
// from each lane in the divide state, then loaded into the output register once it can accept it.
// Measure pixels are taken every cycle while idle; no pixel is taken while a scale pixel is in flight.
// Reset clears the maximum to zero and sets the mask threshold to 0.9.
module masked_max_rgb_normalizer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rgbn_pkg::MASK_BITS-1:0] cfg_wr_data,
    rgbn_in_if.sink                        pixel_in,
    rgbn_out_if.source                     pixel_out
);
    import rgbn_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [STEP_BITS-1:0]  step_reg;
    logic [STEP_BITS-1:0]  step_next;
    logic [MASK_BITS-1:0]  threshold_reg;
    logic [PIXEL_BITS-1:0] max_reg;
    logic [PIXEL_BITS-1:0] max_next;
    logic [PIXEL_BITS-1:0] pixel_peak;
    logic [PIXEL_BITS-1:0] max_base;
    lane_ctrl_t            lane_ctrl;
    logic                  load;
    logic                  can_load;
    logic                  accept;
    logic [OUT_BITS-1:0]   red_res;
    logic [OUT_BITS-1:0]   green_res;
    logic [OUT_BITS-1:0]   blue_res;

    assign pixel_in.ready = (state_reg == ST_IDLE);
    assign accept         = pixel_in.valid && pixel_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        pixel_peak = pixel_in.red_in;
        if (pixel_in.green_in > pixel_peak)
        begin
            pixel_peak = pixel_in.green_in;
        end
        if (pixel_in.blue_in > pixel_peak)
        begin
            pixel_peak = pixel_in.blue_in;
        end
        max_base = pixel_in.first_of_frame ? '0 : max_reg;
        max_next = max_base;
        if ((pixel_in.mask_level > threshold_reg) && (pixel_peak > max_base))
        begin
            max_next = pixel_peak;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else if (accept && (pixel_in.mode == MODE_MEASURE))
        begin
            max_reg <= max_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        lane_ctrl.start = 1'b0;
        lane_ctrl.step  = 1'b0;
        load            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept && (pixel_in.mode == MODE_SCALE))
                begin
                    lane_ctrl.start = 1'b1;
                    state_next      = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                lane_ctrl.step = 1'b1;
                step_next      = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The maximum cannot change while a scale pixel is in flight, so it serves as divisor.
    rgbn_div_lane u_lane_red (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .value   (pixel_in.red_in),
        .divisor (max_reg),
        .result  (red_res)
    );

    rgbn_div_lane u_lane_green (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .value   (pixel_in.green_in),
        .divisor (max_reg),
        .result  (green_res)
    );

    rgbn_div_lane u_lane_blue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .value   (pixel_in.blue_in),
        .divisor (max_reg),
        .result  (blue_res)
    );

    rgbn_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .red_res   (red_res),
        .green_res (green_res),
        .blue_res  (blue_res),
        .maximum   (max_reg),
        .can_load  (can_load),
        .pixel_out (pixel_out)
    );

endmodule

>>> dv/rgbn_result_checker.sv
`timescale 1ns / 1ps
// Checker for the normaliser: follows both channels and the threshold writes, predicts and compares.
module rgbn_result_checker
    import rgbn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MASK_BITS-1:0] cfg_wr_data,
    rgbn_in_if                   pixel_in,
    rgbn_out_if                  pixel_out,
    output int                   mismatches,
    output int                   pending,
    output int                   results_checked,
    output int                   passthroughs,
    output int                   saturations
);

    typedef struct packed {
        logic [OUT_BITS-1:0]   red;
        logic [OUT_BITS-1:0]   green;
        logic [OUT_BITS-1:0]   blue;
        logic                  scaled;
        logic [PIXEL_BITS-1:0] maximum;
    } norm_pixel_t;

    localparam logic [OUT_BITS-1:0] OUT_TOP = {OUT_BITS{1'b1}};

    logic [MASK_BITS-1:0]  mask_limit;
    logic [PIXEL_BITS-1:0] frame_peak;
    norm_pixel_t           normalised_q[$];

    function automatic logic [OUT_BITS-1:0] saturated_quotient(
        input logic [PIXEL_BITS-1:0] channel,
        input logic [PIXEL_BITS-1:0] divisor
    );
        logic [DIVIDEND_BITS-1:0] quotient;
        quotient = {channel, {FRACTION_BITS{1'b0}}} / divisor;
        return (quotient > OUT_TOP) ? OUT_TOP : quotient[OUT_BITS-1:0];
    endfunction

    function automatic norm_pixel_t normalise_pixel(
        input logic [PIXEL_BITS-1:0] red,
        input logic [PIXEL_BITS-1:0] green,
        input logic [PIXEL_BITS-1:0] blue,
        input logic [PIXEL_BITS-1:0] peak
    );
        norm_pixel_t px;
        if (peak == '0)
        begin
            // With nothing to divide by, the channels pass through untouched.
            px.red     = red;
            px.green   = green;
            px.blue    = blue;
            px.scaled  = 1'b0;
            px.maximum = '0;
        end
        else
        begin
            px.red     = saturated_quotient(red, peak);
            px.green   = saturated_quotient(green, peak);
            px.blue    = saturated_quotient(blue, peak);
            px.scaled  = 1'b1;
            px.maximum = peak;
        end
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        norm_pixel_t           want;
        norm_pixel_t           seen;
        logic [PIXEL_BITS-1:0] brightest;
        int                    errs;
        errs = 0;
        if (!rst_n)
        begin
            mask_limit = THRESHOLD_RESET;
            frame_peak = '0;
            normalised_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                mask_limit = cfg_wr_data;

            if (pixel_in.valid && pixel_in.ready)
            begin
                if (pixel_in.mode == MODE_MEASURE)
                begin
                    if (pixel_in.first_of_frame)
                        frame_peak = '0;
                    if (pixel_in.mask_level > mask_limit)
                    begin
                        brightest = pixel_in.red_in;
                        if (pixel_in.green_in > brightest)
                            brightest = pixel_in.green_in;
                        if (pixel_in.blue_in > brightest)
                            brightest = pixel_in.blue_in;
                        if (brightest > frame_peak)
                            frame_peak = brightest;
                    end
                end
                else
                begin
                    normalised_q.push_back(normalise_pixel(pixel_in.red_in, pixel_in.green_in,
                                                           pixel_in.blue_in, frame_peak));
                end
            end

            if (pixel_out.valid && pixel_out.ready)
            begin
                seen.red     = pixel_out.red_out;
                seen.green   = pixel_out.green_out;
                seen.blue    = pixel_out.blue_out;
                seen.scaled  = pixel_out.scaled;
                seen.maximum = pixel_out.frame_maximum;
                if (normalised_q.size() == 0)
                begin
                    $error("result transfer with no scale pixel awaiting it: red_out %0d",
                           seen.red);
                    errs++;
                end
                else
                begin
                    want = normalised_q.pop_front();
                    if (seen.red !== want.red)
                    begin
                        $error("red_out: expected %0d, got %0d", want.red, seen.red);
                        errs++;
                    end
                    if (seen.green !== want.green)
                    begin
                        $error("green_out: expected %0d, got %0d", want.green, seen.green);
                        errs++;
                    end
                    if (seen.blue !== want.blue)
                    begin
                        $error("blue_out: expected %0d, got %0d", want.blue, seen.blue);
                        errs++;
                    end
                    if (seen.scaled !== want.scaled)
                    begin
                        $error("scaled: expected %0d, got %0d", want.scaled, seen.scaled);
                        errs++;
                    end
                    if (seen.maximum !== want.maximum)
                    begin
                        $error("frame_maximum: expected %0d, got %0d", want.maximum,
                               seen.maximum);
                        errs++;
                    end
                    if (!want.scaled)
                        passthroughs <= passthroughs + 1;
                    if (want.red == OUT_TOP || want.green == OUT_TOP || want.blue == OUT_TOP)
                        saturations <= saturations + 1;
                end
                results_checked <= results_checked + 1;
            end
            pending    <= normalised_q.size();
            mismatches <= mismatches + errs;
        end
    end

endmodule

>>> dv/tb_masked_max_rgb_normalizer_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, pixel and threshold stimulus, output back-pressure and the verdict.
module tb_masked_max_rgb_normalizer_top;
    import rgbn_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 30;   // lets a scale pixel still in the lanes finish before going on
    localparam int PHASE_ITEMS    = 100;

    typedef struct packed {
        logic                  mode;
        logic                  first_of_frame;
        logic [PIXEL_BITS-1:0] red;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] blue;
        logic [MASK_BITS-1:0]  mask;
    } pixel_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [MASK_BITS-1:0] cfg_wr_data;
    logic [MASK_BITS-1:0] threshold_now;

    int send_idle_pct;
    int sink_stall_pct;
    int hold_requests;
    int items_sent;
    int quiet_cycles;
    int mismatches;
    int pending;
    int results_checked;
    int passthroughs;
    int saturations;

    rgbn_in_if  pixel_in ();
    rgbn_out_if pixel_out ();

    masked_max_rgb_normalizer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pixel_in    (pixel_in),
        .pixel_out   (pixel_out)
    );

    rgbn_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .pixel_in        (pixel_in),
        .pixel_out       (pixel_out),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .passthroughs    (passthroughs),
        .saturations     (saturations)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : sink_side
        int holds_served;
        holds_served    = 0;
        pixel_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                pixel_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pixel_out.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_in.valid && pixel_in.ready) || (pixel_out.valid && pixel_out.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_masked_max_rgb_normalizer_top NOT OK");
        $finish;
    end

    function automatic pixel_item_t make_pixel(
        input logic                  mode,
        input logic                  first_of_frame,
        input logic [PIXEL_BITS-1:0] red,
        input logic [PIXEL_BITS-1:0] green,
        input logic [PIXEL_BITS-1:0] blue,
        input logic [MASK_BITS-1:0]  mask
    );
        pixel_item_t px;
        px.mode           = mode;
        px.first_of_frame = first_of_frame;
        px.red            = red;
        px.green          = green;
        px.blue           = blue;
        px.mask           = mask;
        return px;
    endfunction

    // Dim levels keep the maximum small, so that ordinary pixels drive the quotient into saturation.
    function automatic logic [PIXEL_BITS-1:0] pick_level(input bit dim);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return PIXEL_BITS'($urandom_range(1, 15));
            default: return dim ? PIXEL_BITS'($urandom_range(1, 255)) : PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic pixel_item_t random_pixel(input bit dim);
        pixel_item_t px;
        px.mode           = MODE_MEASURE;
        px.first_of_frame = 1'b0;
        if ($urandom_range(1) == 1)
            px.mode = MODE_SCALE;
        if ($urandom_range(1) == 1)
            px.first_of_frame = 1'b1;
        px.red   = pick_level(dim);
        px.green = pick_level(dim);
        px.blue  = pick_level(dim);
        // Mask levels cluster round the threshold so that the strict comparison is exercised.
        case ($urandom_range(5))
            0:       px.mask = threshold_now;
            1:       px.mask = threshold_now + 1'b1;
            2:       px.mask = threshold_now - 1'b1;
            3:       px.mask = '1;
            default: px.mask = MASK_BITS'($urandom);
        endcase
        return px;
    endfunction

    // Leaves valid high after the transfer; whoever follows either offers again or lowers it.
    task automatic offer_pixel(input pixel_item_t px);
        if ($urandom_range(99) < send_idle_pct)
        begin
            pixel_in.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        pixel_in.valid          <= 1'b1;
        pixel_in.mode           <= px.mode;
        pixel_in.first_of_frame <= px.first_of_frame;
        pixel_in.red_in         <= px.red;
        pixel_in.green_in       <= px.green;
        pixel_in.blue_in        <= px.blue;
        pixel_in.mask_level     <= px.mask;
        do @(posedge clk); while (!pixel_in.ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        pixel_in.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [MASK_BITS-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        threshold_now = value;
    endtask

    // A frame: a measure pass opened by first-of-frame, then a short scale pass.
    task automatic send_frame();
        pixel_item_t px;
        int          measure_len;
        int          scale_len;
        bit          dim;
        measure_len = $urandom_range(1, 10);
        scale_len   = $urandom_range(1, 5);
        dim         = ($urandom_range(7) == 0);
        for (int i = 0; i < measure_len; i++)
        begin
            px                = random_pixel(dim);
            px.mode           = MODE_MEASURE;
            px.first_of_frame = (i == 0);
            offer_pixel(px);
        end
        for (int i = 0; i < scale_len; i++)
        begin
            px      = random_pixel(1'b0);
            px.mode = MODE_SCALE;
            offer_pixel(px);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [MASK_BITS-1:0] threshold);
        int goal;
        write_threshold(threshold);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        goal           = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(99) < 15)
                offer_pixel(random_pixel(1'b0));
            else
                send_frame();
        end
    endtask

    initial
    begin
        pixel_item_t px;
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_wr_data             = '0;
        threshold_now           = THRESHOLD_RESET;
        pixel_in.valid          = 1'b0;
        pixel_in.mode           = MODE_MEASURE;
        pixel_in.first_of_frame = 1'b0;
        pixel_in.red_in         = '0;
        pixel_in.green_in       = '0;
        pixel_in.blue_in        = '0;
        pixel_in.mask_level     = '0;
        send_idle_pct           = 0;
        sink_stall_pct          = 0;
        hold_requests           = 0;
        items_sent              = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scaling before anything was measured passes the pixel through.
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'h1234, 16'hFFFF, 16'h0000, 16'h0000));
        offer_pixel(make_pixel(MODE_MEASURE, 1'b1, 16'd100, 16'd200, 16'd50, 16'hFFFF));
        // A mask level equal to the threshold does not count; one above it does.
        offer_pixel(make_pixel(MODE_MEASURE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               THRESHOLD_RESET));
        offer_pixel(make_pixel(MODE_MEASURE, 1'b0, 16'd7, 16'd8, 16'd300,
                               THRESHOLD_RESET + 1'b1));
        // First-of-frame is ignored in a scale pass; green overflows, the rest truncate.
        offer_pixel(make_pixel(MODE_SCALE, 1'b1, 16'd300, 16'hFFFF, 16'd0, 16'd0));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'd150, 16'd299, 16'd1, 16'd0));
        offer_pixel(make_pixel(MODE_MEASURE, 1'b1, 16'd0, 16'd0, 16'd0, 16'hFFFF));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'hFFFF, 16'd1, 16'd0, 16'd0));
        offer_pixel(make_pixel(MODE_MEASURE, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'hFFFF, 16'd0, 16'd1, 16'd0));
        // With a maximum of one, a quotient of exactly 2^20 must saturate as well.
        offer_pixel(make_pixel(MODE_MEASURE, 1'b1, 16'd1, 16'd0, 16'd0, 16'hFFFF));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'hFFFF, 16'd16, 16'd15, 16'd0));
        offer_pixel(make_pixel(MODE_MEASURE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'd1, 16'd2, 16'd3, 16'hFFFF));
        // First-of-frame on a pixel below the threshold still clears the maximum.
        offer_pixel(make_pixel(MODE_MEASURE, 1'b1, 16'd5000, 16'd5000, 16'd5000, 16'd0));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'd5000, 16'd5000, 16'd5000, 16'd0));

        write_threshold('0);
        offer_pixel(make_pixel(MODE_MEASURE, 1'b1, 16'd500, 16'd0, 16'd0, 16'd0));
        offer_pixel(make_pixel(MODE_MEASURE, 1'b0, 16'd0, 16'd500, 16'd0, 16'd1));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'd250, 16'd500, 16'd1000, 16'd0));

        write_threshold('1);
        offer_pixel(make_pixel(MODE_MEASURE, 1'b1, 16'd9, 16'd0, 16'd0, 16'hFFFF));
        offer_pixel(make_pixel(MODE_SCALE, 1'b0, 16'd9, 16'd9, 16'd9, 16'd0));

        run_phase(0, 0, MASK_BITS'($urandom));

        // Long output hold-off while scale pixels keep coming, so that the input backs up.
        hold_requests++;
        repeat (8)
        begin
            px      = random_pixel(1'b0);
            px.mode = MODE_SCALE;
            offer_pixel(px);
        end

        run_phase(81, 0, '0);
        run_phase(0, 81, MASK_BITS'($urandom));
        run_phase(35, 35, THRESHOLD_RESET);

        wait_drained();

        $display("Run covered %0d pixels over four flow-control phases; %0d results checked.",
                 items_sent, results_checked);
        $display("Of those, %0d passed through on a zero maximum and %0d had a saturated channel.",
                 passthroughs, saturations);
        if (mismatches == 0 && pending == 0)
            $display("tb_masked_max_rgb_normalizer_top OK");
        else
            $display("tb_masked_max_rgb_normalizer_top NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
src/rgbn_pkg.sv
src/rgbn_if.sv
src/rgbn_div_lane.sv
src/rgbn_merge.sv
src/masked_max_rgb_normalizer_top.sv
dv/rgbn_result_checker.sv
dv/tb_masked_max_rgb_normalizer_top.sv
